// ----- src/ecam_pkg.sv -----
package ecam_pkg;

    localparam int MaxVertices = 32;
    localparam int StackDepth  = 1024;
    localparam int VW = $clog2(MaxVertices);
    localparam int SW = $clog2(StackDepth);

    typedef logic [MaxVertices-1:0] row_t;
    typedef logic [VW-1:0]          vtx_t;
    typedef logic [SW:0]            cnt_t;

    localparam logic [1:0] ST_EULER   = 2'd0;
    localparam logic [1:0] ST_UNCONN  = 2'd1;
    localparam logic [1:0] ST_ODD     = 2'd2;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    // datapath operation codes
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DFS_INIT,
        OP_DFS_STEP,
        OP_PAR_STEP,
        OP_EUL_INIT,
        OP_EUL_STEP,
        OP_FETCH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic dfs_done;
        logic par_done;
        logic unconn;
        logic odd;
        logic eul_done;
        logic row_ok;
    } sts_t;

    function automatic vtx_t lowest_bit(input row_t x);
        vtx_t r;
        r = '0;
        for (int i = MaxVertices - 1; i >= 0; i--)
        begin
            if (x[i])
            begin
                r = VW'(i);
            end
        end
        return r;
    endfunction

endpackage

// ----- src/ecam_datapath.sv -----
module ecam_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ecam_pkg::cmd_t       cmd,
    output ecam_pkg::sts_t       sts,
    input  logic [4:0]           row_index,
    input  logic [31:0]          row_bits,
    input  logic [5:0]           vertex_count,
    input  logic [4:0]           start_vertex,
    output logic [4:0]           vertex,
    output logic                 vertex_last,
    output logic                 circuit_empty
);
    import ecam_pkg::*;

    row_t adj [MaxVertices];
    row_t visited_reg;
    vtx_t sstack [MaxVertices];
    logic [VW:0] sdepth_reg;
    vtx_t wstack [StackDepth];
    cnt_t wdepth_reg;
    vtx_t cstore [StackDepth];
    cnt_t clen_reg, rptr_reg;
    vtx_t pidx_reg;
    logic odd_reg;
    vtx_t wtop_reg;

    logic [VW:0] n;
    row_t mask;
    vtx_t s_top, s_lo, e_lo;
    row_t s_open, e_row;

    always_comb
    begin
        n = (vertex_count == 6'd0) ? (VW+1)'(1) :
            (vertex_count > 6'(MaxVertices)) ? (VW+1)'(MaxVertices) : vertex_count[VW:0];
        mask = (n[VW]) ? '1 : ((row_t'(1) << n[VW-1:0]) - row_t'(1));
        s_top = sstack[sdepth_reg[VW-1:0] - VW'(1)];
        s_open = adj[s_top] & mask & ~visited_reg;
        s_lo = lowest_bit(s_open);
        e_row = adj[wtop_reg] & mask;
        e_lo = lowest_bit(e_row);
    end

    assign sts.dfs_done = (sdepth_reg == '0);
    assign sts.unconn   = ((visited_reg & mask) != mask);
    assign sts.par_done = ((VW+1)'(pidx_reg) == n - (VW+1)'(1));
    assign sts.odd      = odd_reg;
    assign sts.eul_done = (wdepth_reg == '0);
    assign sts.row_ok   = (rptr_reg < clen_reg);

    // adjacency and stacks: no reset, written before read
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                adj[row_index] <= row_bits;
            end
            OP_DFS_INIT:
            begin
                sstack[0] <= '0;
            end
            OP_DFS_STEP:
            begin
                if (s_open != '0 && sdepth_reg < n)
                begin
                    sstack[sdepth_reg[VW-1:0]] <= s_lo;
                end
            end
            OP_EUL_INIT:
            begin
                wstack[0] <= ((VW+1)'(start_vertex) >= n) ? '0 : start_vertex;
            end
            OP_EUL_STEP:
            begin
                if (e_row != '0 && wdepth_reg < cnt_t'(StackDepth))
                begin
                    adj[wtop_reg][e_lo] <= 1'b0;
                    // a self loop is a single bit
                    if (e_lo != wtop_reg)
                    begin
                        adj[e_lo][wtop_reg] <= 1'b0;
                    end
                    wstack[wdepth_reg[SW-1:0]] <= e_lo;
                end
                else if (clen_reg < cnt_t'(StackDepth))
                begin
                    cstore[clen_reg[SW-1:0]] <= wtop_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
            sdepth_reg  <= '0;
            wdepth_reg  <= '0;
            clen_reg    <= '0;
            rptr_reg    <= '0;
            pidx_reg    <= '0;
            odd_reg     <= 1'b0;
            wtop_reg    <= '0;
            vertex      <= '0;
            vertex_last <= 1'b0;
            circuit_empty <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_DFS_INIT:
                begin
                    visited_reg <= row_t'(1);
                    sdepth_reg  <= (VW+1)'(1);
                    clen_reg    <= '0;
                    rptr_reg    <= '0;
                    pidx_reg    <= '0;
                    odd_reg     <= 1'b0;
                    // status results carry zero vertex fields
                    vertex      <= '0;
                    vertex_last <= 1'b0;
                    circuit_empty <= 1'b0;
                end
                OP_DFS_STEP:
                begin
                    if (s_open != '0 && sdepth_reg < n)
                    begin
                        visited_reg[s_lo] <= 1'b1;
                        sdepth_reg <= sdepth_reg + (VW+1)'(1);
                    end
                    else
                    begin
                        sdepth_reg <= sdepth_reg - (VW+1)'(1);
                    end
                end
                OP_PAR_STEP:
                begin
                    if (^(adj[pidx_reg] & mask))
                    begin
                        odd_reg <= 1'b1;
                    end
                    pidx_reg <= pidx_reg + VW'(1);
                end
                OP_EUL_INIT:
                begin
                    wdepth_reg <= cnt_t'(1);
                    wtop_reg <= ((VW+1)'(start_vertex) >= n) ? '0 : start_vertex;
                end
                OP_EUL_STEP:
                begin
                    if (e_row != '0 && wdepth_reg < cnt_t'(StackDepth))
                    begin
                        wdepth_reg <= wdepth_reg + cnt_t'(1);
                        wtop_reg <= e_lo;
                    end
                    else
                    begin
                        if (clen_reg < cnt_t'(StackDepth))
                        begin
                            clen_reg <= clen_reg + cnt_t'(1);
                        end
                        wdepth_reg <= wdepth_reg - cnt_t'(1);
                        if (wdepth_reg > cnt_t'(1))
                        begin
                            wtop_reg <= wstack[SW'(wdepth_reg - cnt_t'(2))];
                        end
                    end
                end
                OP_FETCH:
                begin
                    if (rptr_reg < clen_reg)
                    begin
                        vertex <= cstore[SW'(clen_reg - cnt_t'(1) - rptr_reg)];
                        vertex_last <= (rptr_reg + cnt_t'(1) == clen_reg);
                        circuit_empty <= 1'b0;
                        rptr_reg <= rptr_reg + cnt_t'(1);
                    end
                    else
                    begin
                        vertex <= '0;
                        vertex_last <= 1'b0;
                        circuit_empty <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- src/ecam_ctrl.sv -----
module ecam_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           action,
    input  logic           row_last,
    input  ecam_pkg::sts_t sts,
    output ecam_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done,
    output logic           kind,
    output logic [1:0]     status
);
    import ecam_pkg::*;

    // S_DINI and S_EINI hold the controller while the setup op runs
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_DINI = 8'b00000010,
        S_DFS  = 8'b00000100,
        S_PAR  = 8'b00001000,
        S_EINI = 8'b00010000,
        S_EUL  = 8'b00100000,
        S_REP  = 8'b01000000,
        S_FET  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] stat_reg, stat_next;

    always_comb
    begin
        state_next = state_reg;
        stat_next  = stat_reg;
        cmd.op = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start && action == ACT_LOAD)
                begin
                    cmd.op = OP_LOAD;
                    if (row_last)
                    begin
                        state_next = S_DINI;
                    end
                end
                else if (start)
                begin
                    cmd.op = OP_FETCH;
                    state_next = S_FET;
                end
            end
            S_DINI:
            begin
                state_next = S_DFS;
            end
            S_DFS:
            begin
                if (sts.dfs_done)
                begin
                    if (sts.unconn)
                    begin
                        stat_next = ST_UNCONN;
                        state_next = S_REP;
                    end
                    else
                    begin
                        state_next = S_PAR;
                    end
                end
                else
                begin
                    cmd.op = OP_DFS_STEP;
                end
            end
            S_PAR:
            begin
                cmd.op = OP_PAR_STEP;
                if (sts.par_done)
                begin
                    state_next = S_EINI;
                end
            end
            S_EINI:
            begin
                if (sts.odd)
                begin
                    stat_next = ST_ODD;
                    state_next = S_REP;
                end
                else
                begin
                    state_next = S_EUL;
                end
            end
            S_EUL:
            begin
                if (sts.eul_done)
                begin
                    stat_next = ST_EULER;
                    state_next = S_REP;
                end
                else
                begin
                    cmd.op = OP_EUL_STEP;
                end
            end
            S_REP, S_FET:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stat_reg  <= ST_EULER;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_REP) || (state_reg == S_FET);
    assign kind   = (state_reg == S_FET) ? KIND_VERTEX : KIND_STATUS;
    assign status = (state_reg == S_REP) ? stat_reg : ST_EULER;

endmodule

// ----- src/ecam_seq.sv -----
module ecam_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  ecam_pkg::cmd_t cmd_in,
    input  logic           enter_dfs,
    input  logic           enter_eul,
    output ecam_pkg::cmd_t cmd_out
);
    import ecam_pkg::*;

    // setup ops are issued in the cycle after a phase entry pulse
    logic dfs_reg, eul_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dfs_reg <= 1'b0;
            eul_reg <= 1'b0;
        end
        else
        begin
            dfs_reg <= enter_dfs;
            eul_reg <= enter_eul;
        end
    end

    always_comb
    begin
        cmd_out = cmd_in;
        if (dfs_reg)
        begin
            cmd_out.op = OP_DFS_INIT;
        end
        else if (eul_reg)
        begin
            cmd_out.op = OP_EUL_INIT;
        end
    end

endmodule

// ----- src/euler_circuit_adjacency_matrix.sv -----
// Euler circuit engine for an undirected graph of up to 32 vertices.
// Items are commands: a load writes one adjacency row; a load marked last
// also runs a connectivity search from vertex 0 and, when the graph is
// connected, a parity pass over the rows and, when it is Eulerian, a
// Hierholzer walk, then reports one status result. Busy stays high meanwhile;
// the search, parity and walk run one step per cycle, each step reading one
// adjacency row. A fetch result shows in the cycle after the fetch is
// accepted. Each result is shown for one cycle under done; the receiver
// cannot stall it, so it must take it then. The walk consumes the loaded
// edges; reload the matrix before another build. Configuration may
// only be written while idle.
module euler_circuit_adjacency_matrix (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [4:0]  row_index,
    input  logic [31:0] row_bits,
    input  logic        row_last,
    output logic        done,
    output logic        kind,
    output logic [1:0]  status,
    output logic [4:0]  vertex,
    output logic        vertex_last,
    output logic        circuit_empty
);
    import ecam_pkg::*;

    localparam logic [2:0] ADDR_VCOUNT = 3'd0;
    localparam logic [2:0] ADDR_START  = 3'd4;

    logic [5:0] vcount_reg;
    logic [4:0] svert_reg;
    cmd_t ctrl_cmd, dp_cmd;
    sts_t sts;
    logic busy_q;
    logic par_q;
    logic wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= 6'd32;
            svert_reg  <= 5'd0;
        end
        else if (wr)
        begin
            if (paddr == ADDR_VCOUNT)
            begin
                vcount_reg <= pwdata[5:0];
            end
            else if (paddr == ADDR_START)
            begin
                svert_reg <= pwdata[4:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_VCOUNT)
        begin
            prdata = {26'd0, vcount_reg};
        end
        else if (paddr == ADDR_START)
        begin
            prdata = {27'd0, svert_reg};
        end
    end

    ecam_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .action(action),
        .row_last(row_last), .sts(sts), .cmd(ctrl_cmd), .busy(busy_q),
        .done(done), .kind(kind), .status(status)
    );

    // phase entry pulses: search setup after a last row, walk setup after parity
    logic enter_dfs, enter_eul;
    assign enter_dfs = start && !busy_q && action == ACT_LOAD && row_last;
    assign enter_eul = (ctrl_cmd.op == OP_PAR_STEP) && sts.par_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_q <= 1'b0;
        end
        else
        begin
            par_q <= enter_dfs;
        end
    end

    ecam_seq u_seq (
        .clk(clk), .rst_n(rst_n), .cmd_in(ctrl_cmd), .enter_dfs(enter_dfs),
        .enter_eul(enter_eul), .cmd_out(dp_cmd)
    );

    ecam_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(dp_cmd), .sts(sts),
        .row_index(row_index), .row_bits(row_bits), .vertex_count(vcount_reg),
        .start_vertex(svert_reg), .vertex(vertex), .vertex_last(vertex_last),
        .circuit_empty(circuit_empty)
    );

    assign busy = busy_q;

    // a result, status or vertex, never coincides with an accepted new command
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !(start && !busy))
        else $error("result while idle");
    // a last row makes the block busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n) par_q |-> busy)
        else $error("build did not start");
    // results with the empty flag set are vertex kind
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && circuit_empty) |-> kind == KIND_VERTEX)
        else $error("empty flag on status");

endmodule

// ----- sim/euler_circuit_adjacency_matrix_test.sv -----
`timescale 1ns / 100ps

module euler_circuit_adjacency_matrix_test;
    import ecam_pkg::*;

    // register byte addresses on the config port
    localparam logic [2:0] REG_VERTEX_COUNT = 3'd0;
    localparam logic [2:0] REG_START_VERTEX = 3'd4;

    // cycles with no item and no result before the run is called hung
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct packed {
        logic       kind;
        logic [1:0] status;
        logic [4:0] vertex;
        logic       vertex_last;
        logic       circuit_empty;
    } euler_result_t;

    // scoreboard: holds its own copy of the matrix, the circuit and the config,
    // and predicts the result of each accepted item
    class euler_scoreboard;
        logic [31:0]   adj [32];
        int            vcount;
        int            svert;
        int            circ [1024];
        int            clen;
        int            rptr;
        euler_result_t pending [$];
        int            mismatches;
        int            checked;
        int            builds;
        int            euler_builds;
        int            fetched;

        function new();
            vcount = 32;
            svert = 0;
            clen = 0;
            rptr = 0;
            mismatches = 0;
            checked = 0;
            builds = 0;
            euler_builds = 0;
            fetched = 0;
            foreach (adj[i]) adj[i] = '0;
        endfunction

        function void write_reg(logic [2:0] addr, logic [31:0] val);
            if (addr == REG_VERTEX_COUNT) vcount = int'(val[5:0]);
            else if (addr == REG_START_VERTEX) svert = int'(val[4:0]);
        endfunction

        function int lowest_set(logic [31:0] x);
            for (int i = 0; i < 32; i++)
            begin
                if (x[i]) return i;
            end
            return 31;
        endfunction

        function void note_item(logic act, logic [4:0] idx, logic [31:0] bits, logic last);
            euler_result_t r;
            int            n;
            logic [31:0]   mask;
            logic [31:0]   vis;
            logic [31:0]   open;
            int            stk [32];
            int            ws [1024];
            int            d;
            int            v;
            int            w;
            logic          odd;
            r = '{KIND_STATUS, ST_EULER, 5'd0, 1'b0, 1'b0};
            if (act == ACT_LOAD)
            begin
                adj[idx] = bits;
                if (!last) return;
                n = (vcount == 0) ? 1 : (vcount > 32 ? 32 : vcount);
                mask = (n == 32) ? 32'hffff_ffff : ((32'd1 << n) - 32'd1);
                clen = 0;
                rptr = 0;
                builds++;
                // depth-first search from vertex 0, lowest neighbor first
                vis = 32'd1;
                stk[0] = 0;
                d = 1;
                while (d > 0)
                begin
                    v = stk[d-1];
                    open = adj[v] & mask & ~vis;
                    if (open != 0 && d < n)
                    begin
                        w = lowest_set(open);
                        vis[w] = 1'b1;
                        stk[d] = w;
                        d++;
                    end
                    else d--;
                end
                odd = 1'b0;
                for (int i = 0; i < n; i++)
                begin
                    if ($countones(adj[i] & mask) % 2 != 0) odd = 1'b1;
                end
                if ((vis & mask) != mask) r.status = ST_UNCONN;
                else if (odd) r.status = ST_ODD;
                else r.status = ST_EULER;
                if (r.status == ST_EULER)
                begin
                    // hierholzer walk, consuming edges in both directions
                    euler_builds++;
                    ws[0] = (svert >= n) ? 0 : svert;
                    d = 1;
                    while (d > 0)
                    begin
                        v = ws[d-1];
                        open = adj[v] & mask;
                        if (open != 0 && d < 1024)
                        begin
                            w = lowest_set(open);
                            adj[v][w] = 1'b0;
                            adj[w][v] = 1'b0;
                            ws[d] = w;
                            d++;
                        end
                        else
                        begin
                            if (clen < 1024)
                            begin
                                circ[clen] = v;
                                clen++;
                            end
                            d--;
                        end
                    end
                end
            end
            else
            begin
                r.kind = KIND_VERTEX;
                if (rptr < clen)
                begin
                    r.vertex = 5'(circ[clen - 1 - rptr]);
                    r.vertex_last = (rptr + 1 == clen);
                    rptr++;
                    fetched++;
                end
                else r.circuit_empty = 1'b1;
            end
            pending.push_back(r);
        endfunction

        function void check_result(euler_result_t got);
            euler_result_t exp;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d status=%0d vertex=%0d last=%0d empty=%0d",
                             got.kind, got.status, got.vertex, got.vertex_last,
                             got.circuit_empty);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp k=%0d s=%0d v=%0d l=%0d e=%0d got %0d %0d %0d %0d %0d",
                             exp.kind, exp.status, exp.vertex, exp.vertex_last,
                             exp.circuit_empty, got.kind, got.status, got.vertex,
                             got.vertex_last, got.circuit_empty);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic        action;
    logic [4:0]  row_index;
    logic [31:0] row_bits;
    logic        row_last;
    logic        done;
    logic        kind;
    logic [1:0]  status;
    logic [4:0]  vertex;
    logic        vertex_last;
    logic        circuit_empty;

    euler_scoreboard sb;
    int              items_sent;
    bit              idle_on;
    int              cur_n;

    euler_circuit_adjacency_matrix dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .row_index     (row_index),
        .row_bits      (row_bits),
        .row_last      (row_last),
        .done          (done),
        .kind          (kind),
        .status        (status),
        .vertex        (vertex),
        .vertex_last   (vertex_last),
        .circuit_empty (circuit_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // results are shown for one cycle only, so every done is taken
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result('{kind, status, vertex, vertex_last, circuit_empty});
    end

    // watchdog: cycles in which neither an item nor a result moves
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done === 1'b1) quiet = 0;
            else quiet++;
        end
        $display("watchdog expired after %0d quiet cycles", STALL_LIMIT);
        $display("[euler_circuit_adjacency_matrix] ERROR");
        $finish;
    end

    // one item; called at a falling edge, returns at the falling edge after acceptance
    task automatic issue(logic act, logic [4:0] idx, logic [31:0] bits, logic last);
        if (idle_on && $urandom_range(0, 99) < 6)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        start <= 1'b1;
        action <= act;
        row_index <= idx;
        row_bits <= bits;
        row_last <= last;
        do @(posedge clk); while (busy);
        sb.note_item(act, idx, bits, last);
        items_sent++;
        @(negedge clk);
    endtask

    // drop start and let every expected result arrive, plus the tail of a build
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(addr, val);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(logic [31:0] nval, logic [31:0] sval);
        drain();
        reg_write(REG_VERTEX_COUNT, nval);
        reg_write(REG_START_VERTEX, sval);
        cur_n = (nval[5:0] == 0) ? 1 : (nval[5:0] > 32 ? 32 : int'(nval[5:0]));
    endtask

    function automatic void flip_edge(ref logic [31:0] g [32], input int a, input int b);
        g[a][b] = ~g[a][b];
        g[b][a] = ~g[b][a];
    endfunction

    // random graph on cur_n vertices: mostly even-degree connected ones
    function automatic void make_graph(ref logic [31:0] g [32]);
        int          perm [32];
        int          mode;
        int          t;
        int          j;
        int          a;
        int          b;
        int          c;
        logic [31:0] hi;
        mode = $urandom_range(0, 9);
        hi = (cur_n == 32) ? 32'd0 : ~((32'd1 << cur_n) - 32'd1);
        foreach (g[i]) g[i] = '0;
        if (mode == 9)
        begin
            // noise: asymmetric rows, self loops
            for (int i = 0; i < cur_n; i++) g[i] = $urandom();
            return;
        end
        if (mode == 7)
        begin
            for (int i = 0; i < cur_n; i++)
                for (int k = i + 1; k < cur_n; k++)
                    if ($urandom_range(0, 2) == 0) flip_edge(g, i, k);
        end
        else
        begin
            for (int i = 0; i < cur_n; i++) perm[i] = i;
            for (int i = cur_n - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                t = perm[i];
                perm[i] = perm[j];
                perm[j] = t;
            end
            if (cur_n >= 3)
                for (int i = 0; i < cur_n; i++)
                    flip_edge(g, perm[i], perm[(i + 1) % cur_n]);
            if (cur_n >= 3)
                repeat ($urandom_range(0, cur_n / 2 + 1))
                begin
                    a = $urandom_range(0, cur_n - 1);
                    b = (a + $urandom_range(1, cur_n - 1)) % cur_n;
                    c = $urandom_range(0, cur_n - 1);
                    if (c != a && c != b)
                    begin
                        flip_edge(g, a, b);
                        flip_edge(g, b, c);
                        flip_edge(g, c, a);
                    end
                end
            if (mode == 8 && cur_n >= 2) flip_edge(g, 0, cur_n - 1);
        end
        // junk above the vertex count must be ignored
        if ($urandom_range(0, 3) == 0)
            for (int i = 0; i < cur_n; i++) g[i] |= $urandom() & hi;
    endfunction

    // load rows in random order, the final one marked, then fetch the circuit
    task automatic run_graph(bit pause_after_build);
        logic [31:0] g [32];
        int          order [32];
        int          j;
        int          t;
        int          nfetch;
        make_graph(g);
        for (int i = 0; i < cur_n; i++) order[i] = i;
        for (int i = cur_n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < cur_n; i++)
        begin
            // an occasional stray fetch in the middle of a load
            if ($urandom_range(0, 40) == 0)
                issue(ACT_FETCH, 5'($urandom()), $urandom(), 1'b0);
            issue(ACT_LOAD, 5'(order[i]), g[order[i]], i == cur_n - 1);
        end
        if (pause_after_build) drain();
        nfetch = sb.clen + $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0) nfetch = $urandom_range(0, sb.clen);
        repeat (nfetch) issue(ACT_FETCH, 5'($urandom()), $urandom(), 1'($urandom()));
    endtask

    initial
    begin
        logic [31:0] nval;
        logic [31:0] sval;
        int          pick;
        sb = new();
        items_sent = 0;
        idle_on = 1'b1;
        cur_n = 32;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        action = ACT_LOAD;
        row_index = '0;
        row_bits = '0;
        row_last = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: fetch before any build
        issue(ACT_FETCH, 5'd31, 32'hffff_ffff, 1'b1);
        // zero vertex count acts as one vertex: trivial circuit
        configure(32'd0, 32'd0);
        issue(ACT_LOAD, 5'd0, 32'hffff_fffe, 1'b1);
        issue(ACT_FETCH, 5'd0, 32'd0, 1'b0);
        issue(ACT_FETCH, 5'd0, 32'd0, 1'b0);
        // triangle from the highest vertex, start above the count falls back to 0
        configure(32'd3, 32'd31);
        issue(ACT_LOAD, 5'd2, 32'h0000_0003, 1'b0);
        issue(ACT_LOAD, 5'd1, 32'h0000_0005, 1'b0);
        issue(ACT_LOAD, 5'd0, 32'h0000_0006, 1'b1);
        repeat (5) issue(ACT_FETCH, 5'd0, 32'd0, 1'b0);
        // path has odd ends; clearing row 2 alone leaves vertex 2 reachable through row 1
        issue(ACT_LOAD, 5'd0, 32'h0000_0002, 1'b0);
        issue(ACT_LOAD, 5'd1, 32'h0000_0005, 1'b0);
        issue(ACT_LOAD, 5'd2, 32'h0000_0002, 1'b1);
        issue(ACT_FETCH, 5'd0, 32'd0, 1'b0);
        issue(ACT_LOAD, 5'd2, 32'h0000_0000, 1'b1);
        // count above the maximum saturates, start at the top vertex
        configure(32'd63, 32'd31);
        run_graph(1'b1);

        // random phases, each with its own configuration
        while (items_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60) nval = $urandom_range(1, 8);
            else if (pick < 85) nval = $urandom_range(9, 20);
            else if (pick < 95) nval = $urandom_range(21, 32);
            else if ($urandom_range(0, 1) != 0) nval = 32'd0;
            else nval = 32'($urandom_range(33, 63)) | ($urandom() & 32'hffff_ffc0);
            if ($urandom_range(0, 1) != 0) sval = $urandom();
            else if (nval[5:0] == 0) sval = 32'd0;
            else if (nval[5:0] > 32) sval = $urandom_range(0, 31);
            else sval = $urandom_range(0, nval[5:0] - 1);
            configure(nval, sval);
            // a stretch with no gaps in the middle of the run
            idle_on = !(items_sent > 500 && items_sent < 800);
            repeat ($urandom_range(1, 4)) run_graph($urandom_range(0, 9) == 0);
        end
        idle_on = 1'b1;
        drain();

        $display("%0d items, %0d builds (%0d Eulerian), %0d circuit vertices fetched",
                 items_sent, sb.builds, sb.euler_builds, sb.fetched);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[euler_circuit_adjacency_matrix] OK");
        else
            $display("[euler_circuit_adjacency_matrix] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
src/ecam_pkg.sv
src/ecam_datapath.sv
src/ecam_ctrl.sv
src/ecam_seq.sv
src/euler_circuit_adjacency_matrix.sv
sim/euler_circuit_adjacency_matrix_test.sv
